/* rtl/stmv_pkg.sv */
package stmv_pkg;

  localparam int IDX_W      = 10;
  localparam int Q_W        = 32;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;

  // input tdata layout
  localparam int IN_ROW_LSB = 0;
  localparam int IN_COL_LSB = IDX_W;
  localparam int IN_VAL_LSB = 2 * IDX_W;

  // output tdata layout
  localparam int OUT_IDX_LSB = 0;
  localparam int OUT_VAL_LSB = IDX_W;
  localparam int OUT_SAT_BIT = IDX_W + Q_W;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [1:0]            op_t;

  localparam op_t OP_LOAD_X = 2'd0;
  localparam op_t OP_LOAD_Y = 2'd1;
  localparam op_t OP_ENTRY  = 2'd2;
  localparam op_t OP_READ_Y = 2'd3;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef struct packed {
    q_t   q;
    logic hit;
  } sat_q_t;

endpackage

/* rtl/stmv_mul.sv */
module stmv_mul (
  input  logic            clk,
  input  stmv_pkg::q_t    a_i,
  input  stmv_pkg::q_t    b_i,
  output stmv_pkg::sat_q_t res_o
);
  import stmv_pkg::*;

  logic signed [2*Q_W-1:0] prod_nxt;
  logic signed [2*Q_W-1:0] prod_r;
  logic                    fits;

  assign prod_nxt = a_i * b_i;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // floor(prod / 2^16) saturated to Q16.16
  assign fits = (&prod_r[2*Q_W-1:Q_W+15]) | ~(|prod_r[2*Q_W-1:Q_W+15]);

  always_comb begin
    if (fits) begin
      res_o.q   = prod_r[Q_W+15:16];
      res_o.hit = 1'b0;
    end else begin
      res_o.q   = prod_r[2*Q_W-1] ? Q_MIN : Q_MAX;
      res_o.hit = 1'b1;
    end
  end

endmodule

/* rtl/symmetric_triplet_matvec_unit.sv */
// Channel   Direction  Handshake            Payload
// in        slave      in_tvalid/in_tready  tuser: operation; tdata: row, col, value; tlast
// out       master     out_tvalid/out_tready tuser: result_kind; tdata: index, value, saturated
// cfg       write      cfg_we               cfg_wdata: scale
//
// A diagonal entry makes one y update and an off-diagonal entry two:
// each y update runs two passes through the one shared 32x32 multiplier and a
// read-modify-write of y. A skipped entry makes no update; with tlast it still
// gives a done result. x and y stores are not cleared by reset; the sticky flag
// is cleared and scale is reset to 1.0. A stalled result holds in the output register
// while the next item is accepted; a second result waits until that register frees.
module symmetric_triplet_matvec_unit #(
  parameter int VEC_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [stmv_pkg::IN_DATA_W-1:0]     in_tdata,   // row_index, col_index, value, pad
  input  logic [1:0]                         in_tuser,   // operation
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [stmv_pkg::OUT_DATA_W-1:0]    out_tdata,  // read_index, read_value, saturated, pad
  output logic [0:0]                         out_tuser,  // result_kind
  input  logic                               cfg_we,
  input  logic [stmv_pkg::Q_W-1:0]           cfg_wdata
);
  import stmv_pkg::*;

  localparam int AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  function automatic logic [AW-1:0] to_addr(idx_t idx);
    logic [IDX_W+AW-1:0] e;
    e = {{AW{1'b0}}, idx};
    return e[AW-1:0];
  endfunction

  function automatic logic idx_ok(idx_t idx);
    return {{(32-IDX_W){1'b0}}, idx} < 32'(VEC_DEPTH);
  endfunction

  q_t x_mem [VEC_DEPTH];
  q_t y_mem [VEC_DEPTH];

  logic [2:0] state_r, state_nxt;
  q_t         scale_r;
  logic       flag_r;
  idx_t       row_r, col_r;
  q_t         val_r;
  logic       last_r, pass_r, ok_r, hit_r;
  q_t         x_rd_r, y_rd_r;

  logic       out_valid_r, out_kind_r, out_sat_r;
  idx_t       out_idx_r;
  q_t         out_val_r;

  op_t  in_op;
  idx_t in_row, in_col;
  q_t   in_val;
  logic in_fire, in_row_ok, in_col_ok, slot_free;

  logic          x_we, y_we, x_re, y_re, second;
  logic [AW-1:0] x_waddr, y_waddr, x_raddr, y_raddr;
  q_t            y_wdata;

  q_t          mul_a, mul_b;
  sat_q_t      mul_res;
  logic [Q_W:0] sum;
  q_t          sum_q;
  logic        add_hit;

  assign in_op     = in_tuser;
  assign in_row    = in_tdata[IN_ROW_LSB +: IDX_W];
  assign in_col    = in_tdata[IN_COL_LSB +: IDX_W];
  assign in_val    = in_tdata[IN_VAL_LSB +: Q_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign in_row_ok = idx_ok(in_row);
  assign in_col_ok = idx_ok(in_col);
  assign slot_free = ~out_valid_r | out_tready;
  assign second    = ~pass_r & (row_r != col_r);

  stmv_mul u_mul (
    .clk   (clk),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  assign mul_a = (state_r == S_MUL1) ? x_rd_r : scale_r;
  assign mul_b = (state_r == S_MUL1) ? val_r : mul_res.q;

  assign sum = {y_rd_r[Q_W-1], y_rd_r} + {mul_res.q[Q_W-1], mul_res.q};

  always_comb begin
    add_hit = sum[Q_W] != sum[Q_W-1];
    if (add_hit) begin
      sum_q = sum[Q_W] ? Q_MIN : Q_MAX;
    end else begin
      sum_q = sum[Q_W-1:0];
    end
  end

  // store ports
  assign x_we    = in_fire & (in_op == OP_LOAD_X) & in_row_ok;
  assign x_waddr = to_addr(in_row);
  assign y_we    = (in_fire & (in_op == OP_LOAD_Y) & in_row_ok) | (state_r == S_ADD);
  assign y_waddr = (state_r == S_ADD) ? to_addr(pass_r ? col_r : row_r) : to_addr(in_row);
  assign y_wdata = (state_r == S_ADD) ? sum_q : in_val;
  assign x_re    = (in_fire & (in_op == OP_ENTRY)) | ((state_r == S_ADD) & second);
  assign y_re    = (in_fire & ((in_op == OP_ENTRY) | (in_op == OP_READ_Y)))
                 | ((state_r == S_ADD) & second);
  assign x_raddr = (state_r == S_IDLE) ? to_addr(in_col) : to_addr(row_r);
  assign y_raddr = (state_r == S_IDLE) ? to_addr(in_row) : to_addr(col_r);

  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[x_waddr] <= in_val;
    end
    if (x_re) begin
      x_rd_r <= x_mem[x_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (y_we) begin
      y_mem[y_waddr] <= y_wdata;
    end
    if (y_re) begin
      y_rd_r <= y_mem[y_raddr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_ENTRY) begin
            if ((scale_r != '0) & in_row_ok & in_col_ok) begin
              state_nxt = S_MUL1;
            end else if (in_tlast) begin
              state_nxt = S_DONE;
            end
          end else if (in_op == OP_READ_Y) begin
            state_nxt = S_RESP;
          end
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_ADD;
      S_ADD: begin
        if (second) begin
          state_nxt = S_MUL1;
        end else if (last_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DONE, S_RESP: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scale_r     <= 32'sd65536;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        scale_r <= cfg_wdata;
      end
      if ((state_r == S_ADD) & (hit_r | mul_res.hit | add_hit)) begin
        flag_r <= 1'b1;
      end
      if (((state_r == S_DONE) | (state_r == S_RESP)) & slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_r  <= in_row;
      col_r  <= in_col;
      val_r  <= in_val;
      last_r <= in_tlast;
      ok_r   <= in_row_ok;
      pass_r <= 1'b0;
    end else if ((state_r == S_ADD) & second) begin
      pass_r <= 1'b1;
    end
    if (state_r == S_MUL2) begin
      hit_r <= mul_res.hit;
    end
    if (((state_r == S_DONE) | (state_r == S_RESP)) & slot_free) begin
      out_kind_r <= (state_r == S_DONE) ? KIND_DONE : KIND_READ;
      out_idx_r  <= (state_r == S_DONE) ? '0 : row_r;
      out_val_r  <= ((state_r == S_RESP) & ok_r) ? y_rd_r : '0;
      out_sat_r  <= flag_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tuser    = out_kind_r;
  assign out_tdata    = {{(OUT_DATA_W-IDX_W-Q_W-1){1'b0}}, out_sat_r, out_val_r, out_idx_r};

endmodule

/* rtl/stmv_checker.sv */
module stmv_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [1:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [stmv_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]                      out_tuser
);
  import stmv_pkg::*;

  logic in_xfer, out_xfer, sat_seen_r;

  assign in_xfer  = in_tvalid & in_tready;
  assign out_xfer = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_seen_r <= 1'b0;
    end else if (out_xfer & out_tdata[OUT_SAT_BIT]) begin
      sat_seen_r <= 1'b1;
    end
  end

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser == OP_READ_Y) |=> !in_tready)
    else $error("input ready while a read is in flight");

  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && sat_seen_r |-> out_tdata[OUT_SAT_BIT])
    else $error("saturated flag cleared after being reported");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && (out_tuser[0] == KIND_DONE) |-> out_tdata[OUT_SAT_BIT-1:0] == '0)
    else $error("done result carries nonzero index or value");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind symmetric_triplet_matvec_unit stmv_checker u_stmv_checker (.*);
